>>> hdl/multi_lamp_fade_flicker_core_macros.svh
// assertion macros for the multi-lamp fade and flicker core
`ifndef MULTI_LAMP_FADE_FLICKER_CORE_MACROS_SVH
`define MULTI_LAMP_FADE_FLICKER_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define MLFF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define MLFF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mlff_pkg.sv
// types and constants shared by the lamp fade and flicker modules
`default_nettype none

package mlff_pkg;

    typedef struct packed {
        logic [7:0]  lamp;
        logic [15:0] base_level;
        logic        wants_flicker;
        logic [7:0]  group_level;
        logic        event_on;
        logic        event_off;
        logic        flicker_frame;
        logic [11:0] elapsed_ms;
        logic [15:0] fade_ms;
    } mlff_item_t;

    typedef struct packed {
        logic [7:0]  lamp_out;
        logic [15:0] intensity;
        logic        changed;
        logic        lit;
    } mlff_result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic draw_noise;
        logic recip;
        logic scale;
        logic mul_base;
        logic set_tgt;
        logic div_step;
        logic finish;
    } mlff_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_range;
        logic draw;
        logic out_free;
    } mlff_stat_t;

    localparam logic [31:0] NOISE_SEED      = 32'd2463534242;
    localparam logic [15:0] FLICKER_FADE_MS = 16'd80;
    localparam logic [7:0]  SCALE_MIN       = 8'd90;
    localparam logic [7:0]  SCALE_SPAN      = 8'd90;
    // floor(2^32 / 255), quotient estimate is exact or one low
    localparam logic [24:0] RECIP_255       = 25'h1010101;
    localparam logic [7:0]  DIVISOR_255     = 8'd255;
    localparam int          DIV_STEPS       = 8;
    localparam int          DIV_CNT_W       = 3;

endpackage

`default_nettype wire

>>> hdl/multi_lamp_fade_flicker_core.sv
// top level of the multi-lamp fade and flicker core
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   mlff_item_t, one lamp per tick
//   result    out        result_valid / result_stall  mlff_result_t, one per item
//
// an item is taken only once the last one is finished; drawing a new flicker
// target adds the five-step draw through the shared reciprocal multiplier, and a
// lamp at or beyond LAMP_COUNT skips both the draw and the radix-4 divide
// reset clears levels and flicker marks through per-lamp valid bits, no clearing pass
// a stalled result holds only the final step; the item is already taken
`default_nettype none

`include "multi_lamp_fade_flicker_core_macros.svh"

module multi_lamp_fade_flicker_core #(
    parameter int LAMP_COUNT = 256
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_stall,
    input  wire mlff_pkg::mlff_item_t   item,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output mlff_pkg::mlff_result_t      result
);
    import mlff_pkg::*;

    mlff_cmd_t  cmd;
    mlff_stat_t stat;

    mlff_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    mlff_datapath #(
        .LAMP_COUNT (LAMP_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

    // an accepted beat keeps the block busy in the following cycle
    `MLFF_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "not busy after accept")

    // lamps without storage report dark and unchanged
    `MLFF_ASSERT_NOW(a_out_of_range_dark, result_valid && (32'(result.lamp_out) >= LAMP_COUNT), (result.intensity == 16'd0) && !result.changed, "out of range lamp not dark")

    // a new result only appears from work in progress
    `MLFF_ASSERT_NOW(a_result_from_work, $rose(result_valid), $past(item_stall), "result without work")

endmodule

`default_nettype wire

>>> hdl/mlff_ctrl.sv
// sequencing controller for the lamp fade and flicker core
`default_nettype none

module mlff_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire mlff_pkg::mlff_stat_t stat,
    output mlff_pkg::mlff_cmd_t      cmd
);
    import mlff_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_READ     = 4'd1;
    localparam logic [3:0] ST_NOISE    = 4'd2;
    localparam logic [3:0] ST_RECIP_N  = 4'd3;
    localparam logic [3:0] ST_SCALE    = 4'd4;
    localparam logic [3:0] ST_MUL_BASE = 4'd5;
    localparam logic [3:0] ST_RECIP_B  = 4'd6;
    localparam logic [3:0] ST_TARGET   = 4'd7;
    localparam logic [3:0] ST_DIVIDE   = 4'd8;
    localparam logic [3:0] ST_FINISH   = 4'd9;

    logic [3:0]           state_reg;
    logic [3:0]           state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;

    assign item_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (!stat.in_range)
                    state_next = ST_FINISH;
                else if (stat.draw)
                    state_next = ST_NOISE;
                else
                    state_next = ST_TARGET;
            end
            ST_NOISE:
            begin
                cmd.draw_noise = 1'b1;
                state_next     = ST_RECIP_N;
            end
            ST_RECIP_N:
            begin
                cmd.recip  = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_MUL_BASE;
            end
            ST_MUL_BASE:
            begin
                cmd.mul_base = 1'b1;
                state_next   = ST_RECIP_B;
            end
            ST_RECIP_B:
            begin
                cmd.recip  = 1'b1;
                state_next = ST_TARGET;
            end
            ST_TARGET:
            begin
                cmd.set_tgt = 1'b1;
                cnt_next    = '0;
                state_next  = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/mlff_datapath.sv
// datapath: lamp stores, noise generator, reciprocal scaling, divider, slew
`default_nettype none

module mlff_datapath #(
    parameter int LAMP_COUNT = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mlff_pkg::mlff_item_t  item,
    input  wire mlff_pkg::mlff_cmd_t   cmd,
    output mlff_pkg::mlff_stat_t       stat,
    input  wire logic                  result_stall,
    output logic                       result_valid,
    output mlff_pkg::mlff_result_t     result
);
    import mlff_pkg::*;

    localparam int DEPTH = (LAMP_COUNT < 256) ? LAMP_COUNT : 256;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [31:0] noise_step(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

    logic [15:0]      cur_mem  [DEPTH];
    logic [15:0]      held_mem [DEPTH];
    logic [DEPTH-1:0] cur_vld_reg;
    logic [DEPTH-1:0] started_reg;

    mlff_item_t   item_reg;
    logic [15:0]  cur_rd_reg;
    logic [15:0]  held_rd_reg;
    logic [31:0]  noise_reg;
    logic [31:0]  noise_next;
    logic [23:0]  x_reg;
    logic [48:0]  prod_reg;
    logic [7:0]   scale_reg;
    logic [15:0]  target_reg;
    logic [15:0]  fade_reg;
    logic         sat_reg;
    logic [15:0]  rem_reg;
    logic [15:0]  dsh_reg;
    logic [15:0]  quo_reg;
    logic         result_valid_reg;
    mlff_result_t result_reg;

    logic [AW-1:0] in_addr;
    logic [AW-1:0] addr;
    logic [15:0]   base_eff;
    logic          flk;
    logic          lit;
    logic          in_range;
    logic          draw;
    logic          use_held;
    logic [16:0]   q_est;
    logic [24:0]   q_x255;
    logic [24:0]   rem255;
    logic [16:0]   q255;
    logic [15:0]   target;
    logic [15:0]   fade_eff;
    logic [27:0]   dividend;
    logic [16:0]   r1;
    logic          ge1;
    logic [16:0]   r1s;
    logic [16:0]   r2;
    logic          ge2;
    logic [16:0]   r2s;
    logic [15:0]   cur;
    logic [15:0]   step;
    logic [15:0]   level_next;

    assign in_addr = item.lamp[AW-1:0];
    assign addr    = item_reg.lamp[AW-1:0];

    // activity override: event_on wins over event_off
    always_comb
    begin
        if (item_reg.event_on)
            base_eff = {item_reg.group_level, item_reg.group_level};
        else if (item_reg.event_off)
            base_eff = '0;
        else
            base_eff = item_reg.base_level;
    end

    assign flk      = item_reg.wants_flicker && !item_reg.event_on && !item_reg.event_off;
    assign lit      = (base_eff != '0);
    assign in_range = ({5'b0, item_reg.lamp} < 13'(LAMP_COUNT));
    assign draw     = in_range && flk && lit && (item_reg.flicker_frame || !started_reg[addr]);
    assign use_held = flk && lit && !draw;

    assign noise_next = noise_step(noise_reg);

    // x / 255 from the registered reciprocal product plus one correction
    assign q_est  = prod_reg[48:32];
    assign q_x255 = {q_est, 8'b0} - 25'(q_est);
    assign rem255 = 25'(x_reg) - q_x255;
    assign q255   = q_est + 17'(rem255 >= 25'(DIVISOR_255));

    always_comb
    begin
        if (draw)
            target = q255[15:0];
        else if (use_held)
            target = held_rd_reg;
        else
            target = base_eff;
    end

    assign fade_eff = flk ? FLICKER_FADE_MS : item_reg.fade_ms;
    assign dividend = {item_reg.elapsed_ms, 16'b0} - 28'(item_reg.elapsed_ms);

    // two restoring divide steps per cycle
    assign r1  = {rem_reg, dsh_reg[15]};
    assign ge1 = (r1 >= {1'b0, fade_reg});
    assign r1s = ge1 ? (r1 - {1'b0, fade_reg}) : r1;
    assign r2  = {r1s[15:0], dsh_reg[14]};
    assign ge2 = (r2 >= {1'b0, fade_reg});
    assign r2s = ge2 ? (r2 - {1'b0, fade_reg}) : r2;

    assign cur  = cur_vld_reg[addr] ? cur_rd_reg : 16'd0;
    assign step = (quo_reg == '0) ? 16'd1 : quo_reg;

    always_comb
    begin
        if (cur == target_reg)
            level_next = cur;
        else if (sat_reg)
            level_next = target_reg;
        else if (target_reg > cur)
            level_next = ((target_reg - cur) <= step) ? target_reg : (cur + step);
        else
            level_next = ((cur - target_reg) <= step) ? target_reg : (cur - step);
    end

    assign stat.in_range = in_range;
    assign stat.draw     = draw;
    assign stat.out_free = !result_valid_reg || !result_stall;

    // memories, registered read at the accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_rd_reg  <= cur_mem[in_addr];
            held_rd_reg <= held_mem[in_addr];
        end
        if (cmd.set_tgt && !use_held)
            held_mem[addr] <= target;
        if (cmd.finish && in_range)
            cur_mem[addr] <= level_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
        if (cmd.draw_noise)
            x_reg <= 24'(noise_next[7:0]) * 24'(SCALE_SPAN);
        else if (cmd.mul_base)
            x_reg <= 24'(base_eff) * 24'(scale_reg);
        if (cmd.recip)
            prod_reg <= 49'(x_reg) * 49'(RECIP_255);
        if (cmd.scale)
            scale_reg <= SCALE_MIN + q255[7:0];
        if (cmd.set_tgt)
        begin
            target_reg <= target;
            fade_reg   <= fade_eff;
            // step of 65536 or more always reaches the target
            sat_reg    <= (fade_eff == '0) || ({4'b0, dividend[27:16]} >= fade_eff);
            rem_reg    <= 16'(dividend[27:16]);
            dsh_reg    <= dividend[15:0];
            quo_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= r2s[15:0];
            dsh_reg <= {dsh_reg[13:0], 2'b0};
            quo_reg <= {quo_reg[13:0], ge1, ge2};
        end
        if (cmd.finish)
        begin
            result_reg.lamp_out  <= item_reg.lamp;
            result_reg.intensity <= in_range ? level_next : 16'd0;
            result_reg.changed   <= in_range && (level_next != cur);
            result_reg.lit       <= lit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg        <= NOISE_SEED;
            cur_vld_reg      <= '0;
            started_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.draw_noise)
                noise_reg <= noise_next;
            if (cmd.set_tgt && draw)
                started_reg[addr] <= 1'b1;
            if (cmd.finish && in_range)
                cur_vld_reg[addr] <= 1'b1;
            if (cmd.finish)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
